### sv/mglb_pkg.sv
package mglb_pkg;

    localparam int unsigned MAX_SLOTS_DEF    = 256;
    localparam int unsigned MAX_BACKENDS_DEF = 8;

    localparam int unsigned CFG_W = 9;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        FUNC_LOAD_PERM = 2'd0,
        FUNC_LOAD_ADDR = 2'd1,
        FUNC_REBUILD   = 2'd2,
        FUNC_LOOKUP    = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TABLE_SIZE  = 2'd0,
        REG_BACKEND_CNT = 2'd1,
        REG_VALID_MASK  = 2'd2
    } cfg_idx_t;

endpackage

### sv/mglb_modred.sv
// shift-subtract remainder: folds a chunk into an accumulator, one bit per cycle
module mglb_modred (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [8:0]  modulus,
    input  logic [8:0]  acc_in,
    input  logic [31:0] chunk,
    input  logic [5:0]  nbits,
    output logic        done,
    output logic [8:0]  rem
);
    logic [31:0] sh_reg;
    logic [5:0]  cnt_reg;
    logic [8:0]  r_reg;
    logic        busy_reg;
    logic [9:0]  trial;

    assign trial = {r_reg, sh_reg[31]};
    assign rem   = r_reg;

    // one bit of the chunk per cycle, msb first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                r_reg    <= acc_in;
                sh_reg   <= chunk << (6'd32 - nbits);
                cnt_reg  <= nbits;
            end
            else if (busy_reg)
            begin
                r_reg   <= (trial >= {1'b0, modulus}) ? 9'(trial - {1'b0, modulus})
                                                      : trial[8:0];
                sh_reg  <= sh_reg << 1;
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule

### sv/maglev_consistent_hash_balancer.sv
// Maglev consistent-hash balancer. After reset the owner memory is cleared to
// none, one slot per cycle over all 256 slots, before the first transaction is taken.
// A load of a permutation entry or a backend address gives its result the cycle
// after it is accepted. For a lookup, the protocol, source address, source port,
// destination address and destination port are folded into a slot by a
// bit-serial remainder unit, one bit per cycle (104 bits), field by field, then
// the owner and address are read. A rebuild first clears all 256 slots in the
// owner memory, one per cycle, then walks the permutations; each probe does one
// permutation memory read and one owner read, so its length grows with table
// size times backends in the worst case. Every transaction gives one result,
// held in an output register; no new transaction is taken until that result
// has been accepted.
module maglev_consistent_hash_balancer #(
    parameter int unsigned MAX_SLOTS    = mglb_pkg::MAX_SLOTS_DEF,
    parameter int unsigned MAX_BACKENDS = mglb_pkg::MAX_BACKENDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [mglb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mglb_pkg::CFG_W-1:0]     cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [2:0]  backend_sel,
    input  logic [7:0]  perm_position,
    input  logic [7:0]  perm_slot,
    input  logic [31:0] backend_addr,
    input  logic [7:0]  protocol,
    input  logic [31:0] src_addr,
    input  logic [15:0] src_port_num,
    input  logic [31:0] dst_addr,
    input  logic [15:0] dst_port_num,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  slot,
    output logic [3:0]  chosen_backend,
    output logic [31:0] new_dst_addr,
    output logic        status
);
    import mglb_pkg::*;

    localparam int unsigned NB = (MAX_BACKENDS < 8) ? MAX_BACKENDS : 8;
    localparam int unsigned NS = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;
    localparam int unsigned BW = (NB > 1) ? $clog2(NB) : 1;
    localparam logic [3:0]  NONE = 4'(NB);

    typedef enum logic [3:0] {
        S_IDLE, S_HASH, S_HWAIT, S_LK_RD, S_LK_AD, S_CLR, S_RB_NEXT,
        S_RB_PRD, S_RB_ORD, S_RB_CHK, S_OUT
    } state_t;

    // configuration
    logic [8:0] tsize_reg;
    logic [3:0] bcount_reg;
    logic [7:0] vmask_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tsize_reg  <= 9'd7;
            bcount_reg <= 4'd3;
            vmask_reg  <= 8'hFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TABLE_SIZE:  tsize_reg  <= cfg_data;
                REG_BACKEND_CNT: bcount_reg <= cfg_data[3:0];
                REG_VALID_MASK:  vmask_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic [8:0] size;
    logic [3:0] cnt;
    assign size = (tsize_reg == 9'd0) ? 9'd1 : ((tsize_reg > 9'(NS)) ? 9'(NS) : tsize_reg);
    assign cnt  = (bcount_reg > 4'(NB)) ? 4'(NB) : bcount_reg;

    // memories
    logic [7:0]  perm_mem [NB*256];
    logic [3:0]  own_mem  [256];
    logic [31:0] addr_mem [NB];
    logic [7:0]  perm_q;
    logic [3:0]  own_q;
    logic        perm_we, own_we;
    logic [10:0] perm_wa, perm_ra;
    logic [7:0]  own_a;
    logic [3:0]  own_wd;

    always_ff @(posedge clk)
    begin
        if (perm_we) perm_mem[perm_wa] <= perm_slot;
        perm_q <= perm_mem[perm_ra];
    end
    always_ff @(posedge clk)
    begin
        if (own_we) own_mem[own_a] <= own_wd;
        own_q <= own_mem[own_a];
    end

    // remainder unit
    logic       md_start, md_done;
    logic [8:0] md_acc, md_rem;
    logic [31:0] md_chunk;
    logic [5:0]  md_bits;
    mglb_modred u_mod (
        .clk(clk), .rst_n(rst_n), .start(md_start), .modulus(size),
        .acc_in(md_acc), .chunk(md_chunk), .nbits(md_bits),
        .done(md_done), .rem(md_rem)
    );

    state_t      st_reg;
    logic        init_reg;
    logic [2:0]  fld_reg;
    logic [7:0]  slot_reg;
    logic [8:0]  clr_reg;
    logic [8:0]  linked_reg;
    logic [7:0]  act_reg;
    logic [7:0]  np_reg [8];
    logic [2:0]  b_reg;
    logic [8:0]  p_reg;
    logic        prog_reg;
    logic [7:0]  proto_reg;
    logic [31:0] sa_reg, da_reg;
    logic [15:0] sp_reg, dp_reg;

    assign in_ready = (st_reg == S_IDLE) && !out_valid;

    // tuple fields in fold order, protocol first so the remainder starts below the modulus
    always_comb
    begin
        case (fld_reg)
            3'd0:    begin md_chunk = {24'd0, proto_reg}; md_bits = 6'd8;  end
            3'd1:    begin md_chunk = sa_reg;             md_bits = 6'd32; end
            3'd2:    begin md_chunk = {16'd0, sp_reg};    md_bits = 6'd16; end
            3'd3:    begin md_chunk = da_reg;             md_bits = 6'd32; end
            default: begin md_chunk = {16'd0, dp_reg};    md_bits = 6'd16; end
        endcase
    end
    assign md_acc = (fld_reg == 3'd0) ? 9'd0 : md_rem;

    logic acc;
    assign acc = in_valid && in_ready;
    assign perm_we = acc && (func == FUNC_LOAD_PERM) && (32'(backend_sel) < NB);
    assign perm_wa = {backend_sel, perm_position};
    assign perm_ra = {b_reg, p_reg[7:0]};
    assign md_start = (st_reg == S_HASH);

    logic hitfree;
    assign hitfree = ({1'b0, perm_q} < size) && (own_q == NONE);

    always_comb
    begin
        own_we = 1'b0;
        own_wd = NONE;
        own_a  = '0;
        if (st_reg == S_CLR)
        begin
            own_we = 1'b1;
            own_a  = clr_reg[7:0];
        end
        else if (st_reg == S_LK_RD)
            own_a = slot_reg;
        else if (st_reg == S_RB_CHK && hitfree)
        begin
            own_we = 1'b1;
            own_a  = perm_q;
            own_wd = {1'b0, b_reg};
        end
        else if (st_reg == S_RB_CHK)
            own_a = perm_q;
        else if (st_reg == S_RB_ORD)
            own_a = perm_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_CLR;
            init_reg  <= 1'b1;
            clr_reg   <= '0;
            out_valid <= 1'b0;
            for (int i = 0; i < 8; i++) np_reg[i] <= '0;
            act_reg   <= '0;
        end
        else
        begin
            if (out_valid && out_ready) out_valid <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                    if (acc)
                    begin
                        slot           <= '0;
                        chosen_backend <= NONE;
                        new_dst_addr   <= '0;
                        status         <= 1'b0;
                        proto_reg <= protocol; sa_reg <= src_addr; sp_reg <= src_port_num;
                        da_reg <= dst_addr; dp_reg <= dst_port_num;
                        fld_reg <= '0;
                        clr_reg <= '0;
                        case (func)
                            FUNC_LOAD_PERM: out_valid <= 1'b1;
                            FUNC_LOAD_ADDR:
                            begin
                                if (32'(backend_sel) < NB) addr_mem[backend_sel[BW-1:0]] <= backend_addr;
                                out_valid <= 1'b1;
                            end
                            FUNC_REBUILD: st_reg <= S_CLR;
                            default:      st_reg <= S_HASH;
                        endcase
                    end
                S_HASH: st_reg <= S_HWAIT;
                S_HWAIT:
                    if (md_done)
                    begin
                        if (fld_reg == 3'd4)
                        begin
                            slot_reg <= md_rem[7:0];
                            st_reg   <= S_LK_RD;
                        end
                        else
                        begin
                            fld_reg <= fld_reg + 3'd1;
                            st_reg  <= S_HASH;
                        end
                    end
                S_LK_RD: st_reg <= S_LK_AD;
                S_LK_AD:
                begin
                    slot <= slot_reg;
                    if (own_q < NONE)
                    begin
                        chosen_backend <= own_q;
                        new_dst_addr   <= addr_mem[own_q[BW-1:0]];
                    end
                    else
                        status <= 1'b1;
                    out_valid <= 1'b1;
                    st_reg    <= S_IDLE;
                end
                S_CLR:
                begin
                    clr_reg <= clr_reg + 9'd1;
                    if (clr_reg == 9'd255)
                    begin
                        // the clearing pass after reset ends without a result
                        if (init_reg)
                        begin
                            init_reg <= 1'b0;
                            st_reg   <= S_IDLE;
                        end
                        else
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                np_reg[i]  <= '0;
                                act_reg[i] <= (4'(i) < cnt) && (i < NB) && vmask_reg[i];
                            end
                            linked_reg <= '0;
                            b_reg      <= '0;
                            prog_reg   <= 1'b0;
                            p_reg      <= '0;
                            st_reg     <= S_RB_NEXT;
                        end
                    end
                end
                S_RB_NEXT:
                begin
                    // pick current backend or advance round
                    if (linked_reg >= size)
                    begin
                        out_valid <= 1'b1;
                        st_reg    <= S_IDLE;
                    end
                    else if ({1'b0, b_reg} >= cnt)
                    begin
                        if (!prog_reg)
                        begin
                            out_valid <= 1'b1;
                            st_reg    <= S_IDLE;
                        end
                        else
                        begin
                            prog_reg <= 1'b0;
                            b_reg    <= '0;
                        end
                    end
                    else if (!act_reg[b_reg])
                    begin
                        if (b_reg == 3'd7) b_reg <= '0; // cnt is 8
                        if (b_reg == 3'd7) begin prog_reg <= 1'b0; if (!prog_reg) begin out_valid <= 1'b1; st_reg <= S_IDLE; end end
                        else b_reg <= b_reg + 3'd1;
                    end
                    else
                    begin
                        p_reg  <= {1'b0, np_reg[b_reg]};
                        st_reg <= S_RB_PRD;
                    end
                end
                S_RB_PRD:
                begin
                    if (p_reg >= size)
                    begin
                        // backend ran out of permutation, drops out of this rebuild
                        act_reg[b_reg] <= 1'b0;
                        np_reg[b_reg]  <= 8'(size - 9'd1);
                        if (b_reg == 3'd7)
                        begin
                            b_reg    <= '0;
                            prog_reg <= 1'b0;
                            if (!prog_reg)
                            begin
                                out_valid <= 1'b1;
                                st_reg    <= S_IDLE;
                            end
                            else
                                st_reg <= S_RB_NEXT;
                        end
                        else
                        begin
                            b_reg  <= b_reg + 3'd1;
                            st_reg <= S_RB_NEXT;
                        end
                    end
                    else
                        st_reg <= S_RB_ORD;
                end
                S_RB_ORD: st_reg <= S_RB_CHK;
                S_RB_CHK:
                begin
                    if (hitfree)
                    begin
                        np_reg[b_reg] <= p_reg[7:0];
                        linked_reg    <= linked_reg + 9'd1;
                        st_reg        <= S_RB_NEXT;
                        if (b_reg == 3'd7) begin b_reg <= '0; prog_reg <= 1'b0; end
                        else begin b_reg <= b_reg + 3'd1; prog_reg <= 1'b1; end
                    end
                    else
                    begin
                        p_reg  <= p_reg + 9'd1;
                        st_reg <= S_RB_PRD;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // assertions
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> st_reg == S_IDLE) else $error("ready outside idle");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("accept with pending result");
    a_owner_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> chosen_backend <= NONE) else $error("bad owner code");
endmodule
